[rtl/core/modular_exponentiation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word width, sequencer states and the multiplier request and response types.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Width of the modulus, the base, the exponent and the residue.
    localparam int DATA_BITS = 63;

    // Step counter of the bit-serial multiplier.
    localparam int CNT_W = $clog2(DATA_BITS);

    typedef logic [DATA_BITS-1:0] word_t;

    localparam word_t WORD_ONE = word_t'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_REDUCE,
        SEQ_CHECK,
        SEQ_MULT,
        SEQ_SQUARE,
        SEQ_FINISH
    } seq_state_t;

    // Request to the modular multiplier: product of x and y modulo the modulus.
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
    } mm_req_t;

    // Response of the modular multiplier.
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t product;
    } mm_rsp_t;

endpackage

[rtl/core/mexp_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Carries one base and one exponent per beat.
// ----------------------------------------------------------------------------
interface mexp_req_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    word_t base_value;
    word_t exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

[rtl/core/mexp_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Carries one power residue per beat.
// ----------------------------------------------------------------------------
interface mexp_rsp_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    word_t power_residue;

    modport source (output valid, output power_residue, input ready);
    modport sink   (input valid, input power_residue, output ready);
endinterface

[rtl/core/mexp_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the new modulus value per beat.
// ----------------------------------------------------------------------------
interface mexp_cfg_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/mexp_modmul.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-and-add: one multiplier bit per cycle, most significant
// bit first, keeping the partial result below the modulus after every step.
// ----------------------------------------------------------------------------
module mexp_modmul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mexp_pkg::word_t         modulus,
    input  mexp_pkg::mm_req_t       req,
    output mexp_pkg::mm_rsp_t       rsp
);
    import mexp_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_BITS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;

    logic [DATA_BITS+1:0] sum;
    logic [DATA_BITS+1:0] mod_one;
    logic [DATA_BITS+1:0] mod_two;
    logic [DATA_BITS+1:0] step;

    // One step: double the partial result, add x if the multiplier bit is set,
    // then subtract the modulus once or twice, if needed, to bring it back below it.
    always_comb
    begin
        sum     = {1'b0, acc_reg, 1'b0}
                + {2'b00, (y_reg[DATA_BITS-1] ? x_reg : {DATA_BITS{1'b0}})};
        mod_one = {2'b00, modulus};
        mod_two = {1'b0, modulus, 1'b0};
        priority if (sum >= mod_two)
        begin
            step = sum - mod_two;
        end
        else if (sum >= mod_one)
        begin
            step = sum - mod_one;
        end
        else
        begin
            step = sum;
        end
    end

    // Operand loading and step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (busy_reg)
        begin
            acc_next = step[DATA_BITS-1:0];
            y_next   = {y_reg[DATA_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

[rtl/core/mexp_seq.sv]
// ----------------------------------------------------------------------------
// Square-and-multiply sequencer
// Reduces the base, then walks the exponent from its least significant bit,
// issuing multiplies and squares to the shared modular multiplier.
// ----------------------------------------------------------------------------
module mexp_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_pkg::word_t    modulus,
    mexp_req_if.sink           request,
    mexp_rsp_if.source         response,
    output mexp_pkg::mm_req_t  mm_req,
    input  mexp_pkg::mm_rsp_t  mm_rsp
);
    import mexp_pkg::*;

    seq_state_t state_reg, state_next;
    word_t      exp_reg, exp_next;
    word_t      acc_reg, acc_next;
    word_t      sq_reg, sq_next;
    logic       out_valid_reg, out_valid_next;
    word_t      out_data_reg, out_data_next;

    logic accept;
    logic mod_ok;
    logic slot_free;

    assign mod_ok    = |modulus[DATA_BITS-1:1];
    assign accept    = request.valid && request.ready;
    assign slot_free = !out_valid_reg || response.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = mod_ok ? SEQ_REDUCE : SEQ_FINISH;
                end
            end
            SEQ_REDUCE, SEQ_MULT, SEQ_SQUARE:
            begin
                if (mm_rsp.done)
                begin
                    state_next = SEQ_CHECK;
                end
            end
            SEQ_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = SEQ_FINISH;
                end
                else
                begin
                    state_next = exp_reg[0] ? SEQ_MULT : SEQ_SQUARE;
                end
            end
            SEQ_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Handshake and multiplier requests. The base reduction is a product by
    // one with the raw base scanned as the multiplier.
    always_comb
    begin
        request.ready = (state_reg == SEQ_IDLE);
        mm_req.start  = 1'b0;
        mm_req.x      = WORD_ONE;
        mm_req.y      = request.base_value;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                mm_req.start = accept && mod_ok;
            end
            SEQ_CHECK:
            begin
                mm_req.start = (exp_reg != '0);
                mm_req.x     = exp_reg[0] ? acc_reg : sq_reg;
                mm_req.y     = sq_reg;
            end
            SEQ_REDUCE, SEQ_MULT, SEQ_SQUARE, SEQ_FINISH:
            begin
                mm_req.start = 1'b0;
            end
            default:
            begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    // Datapath updates. A finished multiply clears its exponent bit so that
    // the following check issues the square for the same bit, or finishes when no bit is left.
    always_comb
    begin
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    exp_next = request.exponent;
                    acc_next = mod_ok ? WORD_ONE : '0;
                end
            end
            SEQ_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    sq_next = mm_rsp.product;
                end
            end
            SEQ_MULT:
            begin
                if (mm_rsp.done)
                begin
                    acc_next    = mm_rsp.product;
                    exp_next[0] = 1'b0;
                end
            end
            SEQ_SQUARE:
            begin
                if (mm_rsp.done)
                begin
                    sq_next  = mm_rsp.product;
                    exp_next = exp_reg >> 1;
                end
            end
            SEQ_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            SEQ_CHECK:
            begin
                exp_next = exp_reg;
            end
            default:
            begin
                exp_next = exp_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        out_data_reg <= out_data_next;
    end

    assign response.valid         = out_valid_reg;
    assign response.power_residue = out_data_reg;

endmodule

[rtl/core/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation, right-to-left square-and-multiply
//
// Channel    Role   Payload
// request    sink   base_value, exponent
// response   source power_residue
// cfg        sink   data (modulus)
//
// An item runs the base reduction, then one multiply per one bit and one square
// per bit below the top one bit of the exponent on the bit-serial multiplier.
// A modulus below two skips the multiplier, and the residue is zero.
// A new request beat is taken once the previous result sits in the output
// register; a stalled response holds the block only while that register is full.
// Reset sets the modulus to three and empties the block.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    mexp_req_if.sink    request,
    mexp_rsp_if.source  response,
    mexp_cfg_if.sink    cfg
);
    import mexp_pkg::*;

    word_t   modulus_reg;
    word_t   modulus_next;
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    // Modulus register, always ready for a write beat.
    assign cfg.ready    = 1'b1;
    assign modulus_next = (cfg.valid && cfg.ready) ? cfg.data : modulus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= word_t'(3);
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // Sequencer with the output register.
    mexp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .modulus  (modulus_reg),
        .request  (request),
        .response (response),
        .mm_req   (mm_req),
        .mm_rsp   (mm_rsp)
    );

    // Shared bit-serial modular multiplier.
    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // Checks on the sequencer and the multiplier.
    `MEXP_ASSERT_IMP(a_start_when_free, clk, rst_n, mm_req.start, !mm_rsp.busy, "multiplier started while busy")
    `MEXP_ASSERT_NXT(a_start_takes, clk, rst_n, mm_req.start, mm_rsp.busy, "multiplier did not take a start")
    `MEXP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, request.valid && request.ready, !request.ready, "request taken while an item is in work")
    `MEXP_ASSERT_IMP(a_residue_range, clk, rst_n, response.valid && (modulus_reg[DATA_BITS-1:1] != '0), response.power_residue < modulus_reg, "residue not below modulus")

endmodule

[sim/mexp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the request, response and modulus channels of the block. Every
// request beat is turned into an expected power residue by a square-and-
// multiply model of its own. Every response beat is compared with the oldest
// expected residue.
// ----------------------------------------------------------------------------
module mexp_checker (
    input  logic clk,
    input  logic rst_n,
    mexp_req_if  request,
    mexp_rsp_if  response,
    mexp_cfg_if  cfg,
    output int   mismatch_count,
    output int   outstanding
);
    import mexp_pkg::*;

    typedef logic [2*DATA_BITS-1:0] dword_t;

    localparam word_t RESET_MODULUS = word_t'(3);
    localparam int    EXP_DEPTH     = 8;

    typedef logic [$clog2(EXP_DEPTH)-1:0] slot_t;

    word_t modulus_q;
    word_t expected_mem [EXP_DEPTH];
    slot_t wr_ptr;
    slot_t rd_ptr;
    int    fill;

    // Right-to-left binary exponentiation with exact double-width products.
    function automatic word_t predict_power_residue(input word_t base_in,
                                                    input word_t power,
                                                    input word_t modulus);
        word_t  acc;
        word_t  square;
        dword_t product;
        // A modulus of zero or one sends every residue to zero.
        if (modulus < word_t'(2))
            return '0;
        acc    = WORD_ONE;
        square = base_in % modulus;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if (power[i])
            begin
                product = dword_t'(acc) * dword_t'(square);
                acc     = word_t'(product % dword_t'(modulus));
            end
            product = dword_t'(square) * dword_t'(square);
            square  = word_t'(product % dword_t'(modulus));
        end
        return acc;
    endfunction

    // Track the modulus, store predictions in order and compare response beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q      <= RESET_MODULUS;
            mismatch_count <= 0;
            outstanding    <= 0;
            wr_ptr         = '0;
            rd_ptr         = '0;
            fill           = 0;
        end
        else
        begin
            word_t expected;
            int    new_mismatches;
            new_mismatches = 0;

            if (cfg.valid && cfg.ready)
                modulus_q <= cfg.data;

            if (request.valid && request.ready)
            begin
                if (fill >= EXP_DEPTH)
                begin
                    $error("too many request beats in flight: %0d", fill);
                    new_mismatches++;
                end
                else
                begin
                    expected_mem[wr_ptr] = predict_power_residue(request.base_value,
                                                                 request.exponent,
                                                                 modulus_q);
                    wr_ptr = wr_ptr + slot_t'(1);
                    fill++;
                end
            end

            if (response.valid && response.ready)
            begin
                if (fill == 0)
                begin
                    $error("power_residue beat with no result expected: actual %0d",
                           response.power_residue);
                    new_mismatches++;
                end
                else
                begin
                    expected = expected_mem[rd_ptr];
                    rd_ptr   = rd_ptr + slot_t'(1);
                    fill--;
                    if (response.power_residue !== expected)
                    begin
                        $error("power_residue mismatch: expected %0d, actual %0d",
                               expected, response.power_residue);
                        new_mismatches++;
                    end
                end
            end

            mismatch_count <= mismatch_count + new_mismatches;
            outstanding    <= fill;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base and exponent beats and modulus writes into the block, with
// random idling on the request side and random stalls on the response side.
// A directed set covers the field extremes and the degenerate moduli; random
// phases follow with several moduli. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import mexp_pkg::*;

    localparam int    CYCLE_LIMIT  = 8000000;
    localparam int    DRAIN_CYCLES = 64;
    localparam int    PHASE_ITEMS  = 25;
    localparam word_t WORD_MAX     = '1;

    logic clk = 1'b0;
    logic rst_n;

    int    send_idle_pct;
    int    recv_stall_pct;
    int    cycle_count = 0;
    int    mismatch_count;
    int    outstanding;
    word_t cur_modulus;

    mexp_req_if req_ch ();
    mexp_rsp_if rsp_ch ();
    mexp_cfg_if cfg_ch ();

    modular_exponentiation DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .cfg      (cfg_ch)
    );

    mexp_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (req_ch),
        .response       (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Clock with a 20 ns period.
    always #10 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Response side stalls at random.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic word_t random_word();
        return word_t'({$urandom(), $urandom()});
    endfunction

    // One request beat, after an optional random idle stretch.
    task automatic send_request(input word_t base_in, input word_t power);
        int gap_cycles;
        gap_cycles = 0;
        // Now and then a long gap, so that idling lands mid-computation.
        if (send_idle_pct > 0 && $urandom_range(15) == 0)
            gap_cycles = $urandom_range(9000);
        while (gap_cycles > 0 || $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            if (gap_cycles > 0)
                gap_cycles--;
        end
        req_ch.valid      <= 1'b1;
        req_ch.base_value <= base_in;
        req_ch.exponent   <= power;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    // Stop sending and wait until every expected residue has arrived.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One modulus write beat; only called while the block is idle.
    task automatic write_modulus(input word_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        cur_modulus = value;
    endtask

    // Random base and exponent, biased toward edge values and short powers.
    task automatic send_random_request();
        word_t base_in;
        word_t power;
        case ($urandom_range(7))
            0:       base_in = '0;
            1:       base_in = WORD_ONE;
            2:       base_in = cur_modulus - WORD_ONE;
            3:       base_in = WORD_MAX;
            default: base_in = random_word();
        endcase
        case ($urandom_range(3))
            0:       power = word_t'($urandom_range(255));
            1:       power = random_word() >> $urandom_range(DATA_BITS - 1);
            default: power = random_word();
        endcase
        send_request(base_in, power);
    endtask

    // Stimulus and verdict.
    initial
    begin
        word_t phase_modulus;

        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cur_modulus       = word_t'(3);
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.base_value <= '0;
        req_ch.exponent   <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset modulus of three.
        send_request(word_t'(5), word_t'(3));
        send_request(WORD_MAX, WORD_MAX);
        wait_idle();

        // Largest modulus with the field extremes.
        write_modulus(WORD_MAX);
        send_request('0, '0);
        send_request('0, WORD_ONE);
        send_request('0, WORD_MAX);
        send_request(WORD_ONE, '0);
        send_request(WORD_MAX, '0);
        send_request(WORD_MAX, WORD_ONE);
        send_request(WORD_MAX - WORD_ONE, word_t'(2));
        send_request(WORD_MAX, WORD_MAX);
        send_request(word_t'(2), word_t'(62));
        send_request(word_t'(123456789), word_t'(65537));
        wait_idle();

        // A small modulus, with bases below, at and above it.
        write_modulus(word_t'(1000003));
        send_request(word_t'(1000003), word_t'(7));
        send_request(word_t'(1000002), word_t'(3));
        send_request(WORD_MAX, WORD_MAX);
        wait_idle();

        // Modulus zero and modulus one give zero for every input.
        write_modulus('0);
        send_request(word_t'(7), '0);
        send_request(WORD_MAX, WORD_MAX);
        wait_idle();
        write_modulus(WORD_ONE);
        send_request(word_t'(7), '0);
        send_request(WORD_MAX, word_t'(5));
        wait_idle();

        // Smallest meaningful modulus.
        write_modulus(word_t'(2));
        send_request(word_t'(3), WORD_MAX);
        send_request(word_t'(4), word_t'(9));
        send_request(word_t'(4), '0);
        wait_idle();

        // Random phases, each with its own idling pattern and modulus.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    phase_modulus  = random_word() | {1'b1, {(DATA_BITS - 1){1'b0}}};
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                    phase_modulus  = word_t'($urandom_range(1000, 2));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                    phase_modulus  = WORD_MAX;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                    phase_modulus  = random_word() >> $urandom_range(DATA_BITS - 2);
                end
            endcase
            if (phase_modulus < word_t'(2))
                phase_modulus = word_t'(2);
            write_modulus(phase_modulus);
            repeat (PHASE_ITEMS) send_random_request();
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[modular_exponentiation.f]
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_req_if.sv
rtl/core/mexp_rsp_if.sv
rtl/core/mexp_cfg_if.sv
rtl/core/mexp_modmul.sv
rtl/core/mexp_seq.sv
rtl/core/modular_exponentiation.sv
sim/mexp_checker.sv
sim/testbench.sv
